/* hw/rtl/pwm_pulse_capture_peak_report_unit_assert.svh */
// Assertion macros used by the checker file of the pulse capture unit
`ifndef PWM_PULSE_CAPTURE_PEAK_REPORT_UNIT_ASSERT_SVH
`define PWM_PULSE_CAPTURE_PEAK_REPORT_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define PWMPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwmpc assertion failed");

// Next-cycle implication, off while reset is held
`define PWMPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwmpc assertion failed");

`endif

/* hw/rtl/pwmpc_pkg.sv */
// Package: types, constants and helpers of the pulse capture unit
`timescale 1ns / 1ps

package pwmpc_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned WIDTH_W    = 12;
    localparam int unsigned ID_W       = 8;
    localparam int unsigned RATE_W     = 8;
    localparam int unsigned CRATE_W    = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_RATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HARDPOINT   = 1'd1;

    localparam logic [RATE_W-1:0] RATE_RESET = 8'd10;
    localparam logic [ID_W-1:0]   ID_RESET   = 8'd0;

    localparam logic [CRATE_W-1:0] RATE_MIN = 7'd10;
    localparam logic [CRATE_W-1:0] RATE_MAX = 7'd100;

    localparam logic [TIME_W-1:0] WIDTH_MIN_EXCL = 32'd500;
    localparam logic [TIME_W-1:0] WIDTH_MAX_EXCL = 32'd2500;

    // Elapsed time of 1024 ms or more always passes, since the rate is at least 10
    localparam int unsigned        ELAPSED_LO_W = 10;
    localparam int unsigned        PROD_W       = ELAPSED_LO_W + CRATE_W;
    localparam logic [PROD_W-1:0]  PROD_MIN     = 17'd1000;

    localparam logic MODE_EDGE   = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    typedef struct packed {
        logic              mode;
        logic              pin_level;
        logic [TIME_W-1:0] edge_time_us;
        logic [TIME_W-1:0] now_ms;
    } t_in_beat;

    typedef struct packed {
        logic [ID_W-1:0]    report_id;
        logic [WIDTH_W-1:0] peak_width_us;
    } t_out_beat;

    typedef struct packed {
        logic [CRATE_W-1:0] rate_clamped;
        logic [ID_W-1:0]    source_id;
    } t_cfg;

    function automatic logic [CRATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
        logic [CRATE_W-1:0] res;
        if (r < RATE_W'(RATE_MIN)) begin
            res = RATE_MIN;
        end else if (r > RATE_W'(RATE_MAX)) begin
            res = RATE_MAX;
        end else begin
            res = r[CRATE_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/pwmpc_stream_if.sv */
// Interface: valid/ready channel carrying one payload beat
`timescale 1ns / 1ps

interface pwmpc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/pwmpc_cfg.sv */
// Configuration registers: write decode and rate clamping
`timescale 1ns / 1ps

module pwmpc_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pwmpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pwmpc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output pwmpc_pkg::t_cfg                     o_cfg
);

    pwmpc_pkg::t_cfg r_cfg;
    pwmpc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwmpc_pkg::CFG_REPORT_RATE: begin
                    // store the clamped rate so the datapath never sees raw values
                    n_cfg.rate_clamped =
                        pwmpc_pkg::clamp_rate(i_cfg_wdata[pwmpc_pkg::RATE_W-1:0]);
                end
                pwmpc_pkg::CFG_HARDPOINT: begin
                    n_cfg.source_id = i_cfg_wdata[pwmpc_pkg::ID_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate_clamped <= pwmpc_pkg::clamp_rate(pwmpc_pkg::RATE_RESET);
            r_cfg.source_id    <= pwmpc_pkg::ID_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/pwm_pulse_capture_peak_report_unit.sv */
// Top level: pulse width capture with periodic peak report
`timescale 1ns / 1ps

// Usage
//   i_item (sink) takes one beat per item. mode 0 is a pin edge: pin_level is
//   the new level, edge_time_us its microsecond stamp. mode 1 is a report tick
//   carrying now_ms. o_report (source) gives report_id and peak_width_us.
//   The configuration port writes report_rate_hz (index 0, clamped to
//   10..100 when stored) and source_id (index 1); write only while idle.
// Timing
//   An item is processed in the cycle it is accepted; a report, if any, is
//   valid on o_report on the next cycle. One item per cycle is
//   accepted as long as the output register is empty or is being drained.
//   The path that sets this is the 32-bit elapsed-time subtract followed by
//   a 10x7 multiply and compare against 1000, all combinational.
// Reset
//   Synchronous, active low: level, stamps, peak and send time go to zero,
//   rate to 10, id to 0, and the output register empties.
// Stall
//   While a report waits and the receiver holds ready low, i_item.ready
//   drops, so no item is taken and no report can be lost.

module pwm_pulse_capture_peak_report_unit (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [pwmpc_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [pwmpc_pkg::CFG_DATA_W-1:0]            i_cfg_wdata,
    pwmpc_stream_if.sink                                i_item,
    pwmpc_stream_if.source                              o_report
);

    pwmpc_pkg::t_cfg w_cfg;

    pwmpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Capture state
    logic                              r_prev_level;
    logic [pwmpc_pkg::TIME_W-1:0]      r_prev_time;
    logic [pwmpc_pkg::WIDTH_W-1:0]     r_peak;
    logic [pwmpc_pkg::TIME_W-1:0]      r_last_ms;

    // Output register
    logic                              r_out_valid;
    pwmpc_pkg::t_out_beat              r_out;

    logic                              n_prev_level;
    logic [pwmpc_pkg::TIME_W-1:0]      n_prev_time;
    logic [pwmpc_pkg::WIDTH_W-1:0]     n_peak;
    logic [pwmpc_pkg::TIME_W-1:0]      n_last_ms;
    logic                              n_out_valid;
    pwmpc_pkg::t_out_beat              n_out;

    pwmpc_pkg::t_in_beat               w_in;
    logic                              w_accept;
    logic                              w_falling;
    logic [pwmpc_pkg::TIME_W-1:0]      w_width;
    logic                              w_width_ok;
    logic [pwmpc_pkg::TIME_W-1:0]      w_elapsed;
    logic [pwmpc_pkg::PROD_W-1:0]      w_prod;
    logic                              w_due;
    logic                              w_emit;

    assign w_in           = i_item.data;
    // Take a new beat whenever the output register is empty or drains now
    assign i_item.ready   = !r_out_valid || o_report.ready;
    assign w_accept       = i_item.valid && i_item.ready;

    // Edge path: a falling edge after a stamped high level measures the pulse
    assign w_falling  = !w_in.pin_level && r_prev_level && (r_prev_time != '0);
    assign w_width    = w_in.edge_time_us - r_prev_time;
    // Below the upper bound the width fits the peak register
    assign w_width_ok = (w_width > pwmpc_pkg::WIDTH_MIN_EXCL)
                     && (w_width < pwmpc_pkg::WIDTH_MAX_EXCL)
                     && (w_width[pwmpc_pkg::WIDTH_W-1:0] > r_peak);

    // Report path: elapsed * rate >= 1000. Any elapsed of 1024 or more passes
    // outright, so only the low bits go through the multiplier.
    assign w_elapsed = w_in.now_ms - r_last_ms;
    assign w_prod    = pwmpc_pkg::PROD_W'(w_elapsed[pwmpc_pkg::ELAPSED_LO_W-1:0])
                     * pwmpc_pkg::PROD_W'(w_cfg.rate_clamped);
    assign w_due     = (w_elapsed[pwmpc_pkg::TIME_W-1:pwmpc_pkg::ELAPSED_LO_W] != '0)
                    || (w_prod >= pwmpc_pkg::PROD_MIN);
    assign w_emit    = (r_peak != '0) && w_due;

    always_comb begin
        n_prev_level = r_prev_level;
        n_prev_time  = r_prev_time;
        n_peak       = r_peak;
        n_last_ms    = r_last_ms;
        n_out        = r_out;
        // drop the held report once the receiver takes it
        n_out_valid  = r_out_valid && !o_report.ready;

        if (w_accept) begin
            if (w_in.mode == pwmpc_pkg::MODE_EDGE) begin
                if (w_falling && w_width_ok) begin
                    n_peak = w_width[pwmpc_pkg::WIDTH_W-1:0];
                end
                n_prev_level = w_in.pin_level;
                n_prev_time  = w_in.edge_time_us;
            end else begin
                // every tick clears the peak, sent or not
                n_peak = '0;
                if (w_emit) begin
                    n_last_ms           = w_in.now_ms;
                    n_out_valid         = 1'b1;
                    n_out.report_id     = w_cfg.source_id;
                    n_out.peak_width_us = r_peak;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_prev_time  <= '0;
            r_peak       <= '0;
            r_last_ms    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prev_level <= n_prev_level;
            r_prev_time  <= n_prev_time;
            r_peak       <= n_peak;
            r_last_ms    <= n_last_ms;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload holds while a report waits; no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_report.valid = r_out_valid;
    assign o_report.data  = r_out;

endmodule

/* hw/rtl/pwmpc_checker.sv */
// Checker: port-level assertions for the pulse capture unit, bound to the top
`timescale 1ns / 1ps

`include "pwm_pulse_capture_peak_report_unit_assert.svh"

module pwmpc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_in_mode,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [pwmpc_pkg::WIDTH_W-1:0]      i_out_peak
);

    logic w_tick_taken;
    logic w_peak_ok;

    assign w_tick_taken = i_in_valid && i_in_ready && (i_in_mode == pwmpc_pkg::MODE_REPORT);
    assign w_peak_ok    = (i_out_peak > pwmpc_pkg::WIDTH_W'(pwmpc_pkg::WIDTH_MIN_EXCL))
                       && (i_out_peak < pwmpc_pkg::WIDTH_W'(pwmpc_pkg::WIDTH_MAX_EXCL));

    // A waiting report holds until taken
    `PWMPC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A report appears only right after an accepted tick
    `PWMPC_ASSERT_IMP(a_out_from_tick, i_clk, i_rst_n, $rose(i_out_valid), $past(w_tick_taken))

    // A reported peak is always a width inside the accepted window
    `PWMPC_ASSERT_IMP(a_peak_range, i_clk, i_rst_n, i_out_valid, w_peak_ok)

    // An empty output register never blocks the input
    `PWMPC_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind pwm_pulse_capture_peak_report_unit pwmpc_checker u_pwmpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_mode   (i_item.data.mode),
    .i_out_valid (o_report.valid),
    .i_out_ready (o_report.ready),
    .i_out_peak  (o_report.data.peak_width_us)
);
